[design/pctd_pkg.sv]
// pctd_pkg: shared types, character constants and hex helpers for the percent decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pctd_pkg;

    localparam int C_MAX_BYTES   = 3;
    localparam int C_QUEUE_DEPTH = 2;
    localparam int C_QPTR_W      = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int C_QCNT_W      = $clog2(C_QUEUE_DEPTH + 1);

    localparam logic [7:0] C_CHAR_PERCENT = 8'h25;
    localparam logic [7:0] C_CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] C_CHAR_SPACE   = 8'h20;
    localparam logic [7:0] C_CHAR_ZERO    = 8'h30;
    localparam logic [7:0] C_CHAR_NINE    = 8'h39;
    localparam logic [7:0] C_CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] C_CHAR_UPPER_F = 8'h46;
    localparam logic [3:0] C_LETTER_ADJ   = 4'd9;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HEX  = 2'd2
    } t_phase;

    // up to three decoded bytes produced by one input word
    typedef struct packed {
        logic [C_MAX_BYTES-1:0][7:0] bytes;
        logic [1:0]                  count;
        logic                        last;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= C_CHAR_ZERO) && (c <= C_CHAR_NINE)) ||
               ((c >= C_CHAR_UPPER_A) && (c <= C_CHAR_UPPER_F));
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= C_CHAR_NINE) begin
            return c[3:0];
        end
        return c[3:0] + C_LETTER_ADJ;
    endfunction

endpackage

`default_nettype wire

[design/pctd_front.sv]
// pctd_front: escape state machine, turns each input word into a command of 0..3 bytes
// depends on pctd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pctd_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_wr_data,
    input  wire pctd_pkg::t_in_word i_in_word,
    input  wire logic              i_accept,
    output pctd_pkg::t_cmd         o_cmd,
    output logic                   o_push
);

    logic             r_plus_to_space;
    pctd_pkg::t_phase r_phase, n_phase, mid_phase;
    logic [7:0]       r_first, n_first, mid_first;

    logic [7:0] cur;
    logic       cur_hex, first_hex, pair_ok;
    logic [7:0] pair_val;
    logic [1:0] cnt;

    assign cur       = (r_plus_to_space && (i_in_word.in_byte == pctd_pkg::C_CHAR_PLUS)) ?
                       pctd_pkg::C_CHAR_SPACE : i_in_word.in_byte;
    assign cur_hex   = pctd_pkg::is_hex(cur);
    assign first_hex = pctd_pkg::is_hex(r_first);
    assign pair_ok   = cur_hex && first_hex &&
                       !((r_first == pctd_pkg::C_CHAR_ZERO) && (cur == pctd_pkg::C_CHAR_ZERO));
    assign pair_val  = {pctd_pkg::hex_nibble(r_first), pctd_pkg::hex_nibble(cur)};

    // next state: mid_* is the state after the byte, before the end-of-string flush
    always_comb begin
        mid_phase = pctd_pkg::PH_IDLE;
        mid_first = r_first;
        case (r_phase)
            pctd_pkg::PH_PCT: begin
                if (cur_hex) begin
                    mid_phase = pctd_pkg::PH_HEX;
                    mid_first = cur;
                end else if (cur == pctd_pkg::C_CHAR_PERCENT) begin
                    mid_phase = pctd_pkg::PH_PCT;
                end
            end
            pctd_pkg::PH_HEX: begin
                mid_first = '0;
                if (pair_ok) begin
                    if (pair_val == pctd_pkg::C_CHAR_PERCENT) begin
                        mid_phase = pctd_pkg::PH_PCT;
                    end
                end else if (cur == pctd_pkg::C_CHAR_PERCENT) begin
                    mid_phase = pctd_pkg::PH_PCT;
                end
            end
            default: begin
                if (cur == pctd_pkg::C_CHAR_PERCENT) begin
                    mid_phase = pctd_pkg::PH_PCT;
                end
            end
        endcase
        n_phase = i_in_word.in_last ? pctd_pkg::PH_IDLE : mid_phase;
        n_first = i_in_word.in_last ? 8'h00 : mid_first;
    end

    // outputs: bytes emitted in order
    always_comb begin
        o_cmd = '0;
        cnt   = '0;
        case (r_phase)
            pctd_pkg::PH_PCT: begin
                if (!cur_hex) begin
                    o_cmd.bytes[cnt] = pctd_pkg::C_CHAR_PERCENT;
                    cnt = cnt + 2'd1;
                    if (cur != pctd_pkg::C_CHAR_PERCENT) begin
                        o_cmd.bytes[cnt] = cur;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            pctd_pkg::PH_HEX: begin
                if (pair_ok) begin
                    if (pair_val != pctd_pkg::C_CHAR_PERCENT) begin
                        o_cmd.bytes[cnt] = pair_val;
                        cnt = cnt + 2'd1;
                    end
                end else begin
                    o_cmd.bytes[cnt] = pctd_pkg::C_CHAR_PERCENT;
                    cnt = cnt + 2'd1;
                    o_cmd.bytes[cnt] = r_first;
                    cnt = cnt + 2'd1;
                    if (cur != pctd_pkg::C_CHAR_PERCENT) begin
                        o_cmd.bytes[cnt] = cur;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            default: begin
                if (cur != pctd_pkg::C_CHAR_PERCENT) begin
                    o_cmd.bytes[cnt] = cur;
                    cnt = cnt + 2'd1;
                end
            end
        endcase
        // end of string: pending escape goes out literally
        if (i_in_word.in_last) begin
            case (mid_phase)
                pctd_pkg::PH_PCT: begin
                    o_cmd.bytes[cnt] = pctd_pkg::C_CHAR_PERCENT;
                    cnt = cnt + 2'd1;
                end
                pctd_pkg::PH_HEX: begin
                    o_cmd.bytes[cnt] = pctd_pkg::C_CHAR_PERCENT;
                    cnt = cnt + 2'd1;
                    o_cmd.bytes[cnt] = mid_first;
                    cnt = cnt + 2'd1;
                end
                default: begin
                end
            endcase
        end
        o_cmd.count = cnt;
        o_cmd.last  = i_in_word.in_last;
        o_push      = i_accept && (cnt != 2'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus_to_space <= 1'b0;
            r_phase         <= pctd_pkg::PH_IDLE;
            r_first         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_plus_to_space <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_phase <= n_phase;
                r_first <= n_first;
            end
        end
    end

endmodule

`default_nettype wire

[design/pctd_queue.sv]
// pctd_queue: short register queue of byte commands between front and back
// depends on pctd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pctd_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire pctd_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output pctd_pkg::t_cmd      o_head,
    output pctd_pkg::t_q_status o_status
);

    pctd_pkg::t_cmd r_entry [pctd_pkg::C_QUEUE_DEPTH];
    logic [pctd_pkg::C_QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [pctd_pkg::C_QCNT_W-1:0] r_count, n_count;

    localparam logic [pctd_pkg::C_QCNT_W-1:0] C_FULL_CNT =
        pctd_pkg::C_QCNT_W'(pctd_pkg::C_QUEUE_DEPTH);
    localparam logic [pctd_pkg::C_QCNT_W-1:0] C_ONE_CNT =
        pctd_pkg::C_QCNT_W'(1);
    localparam logic [pctd_pkg::C_QPTR_W-1:0] C_LAST_PTR =
        pctd_pkg::C_QPTR_W'(pctd_pkg::C_QUEUE_DEPTH - 1);
    localparam logic [pctd_pkg::C_QPTR_W-1:0] C_ONE_PTR =
        pctd_pkg::C_QPTR_W'(1);

    assign o_head             = r_entry[r_rd_ptr];
    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == C_FULL_CNT);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + C_ONE_CNT;
        end else if (!i_push && i_pop) begin
            n_count = r_count - C_ONE_CNT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == C_LAST_PTR) ? '0 : r_wr_ptr + C_ONE_PTR;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == C_LAST_PTR) ? '0 : r_rd_ptr + C_ONE_PTR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

[design/pctd_back.sv]
// pctd_back: walks the head command one byte per word on the output channel
// depends on pctd_pkg
`timescale 1ns / 1ps
`default_nettype none

module pctd_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire pctd_pkg::t_cmd     i_head,
    input  wire pctd_pkg::t_q_status i_status,
    input  wire logic               i_out_stall,
    output logic                    o_out_valid,
    output pctd_pkg::t_out_word     o_out_word,
    output logic                    o_pop
);

    logic [1:0] r_idx;
    logic       at_end;

    assign at_end              = (r_idx == (i_head.count - 2'd1));
    assign o_out_valid         = i_status.not_empty;
    assign o_out_word.out_byte = i_head.bytes[r_idx];
    assign o_out_word.out_last = i_head.last && at_end;
    assign o_pop               = o_out_valid && !i_out_stall && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_out_valid && !i_out_stall) begin
            r_idx <= at_end ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

`default_nettype wire

[design/percent_decoder.sv]
// percent_decoder: top level of the streaming url percent-escape decoder
// depends on pctd_pkg, pctd_front, pctd_queue, pctd_back
//
// usage
//   input channel: i_in_valid / o_in_stall carry one encoded byte per word, with
//   in_last on the final byte of a string. output channel: o_out_valid / i_out_stall
//   carry one decoded byte per word, out_last on the final decoded byte.
//   a word moves at a clock edge with valid high and stall low.
//   i_cfg_wr_en / i_cfg_wr_data write plus_to_space; write only while the block
//   is idle. it is cleared at reset.
// flow
//   a decoded byte is offered once its command is registered in the queue.
//   one input word per cycle while the queue is not full and one output word per
//   cycle while a command is queued and the output is not stalled; the output
//   side serialises 1 to 3 bytes per input word, one per cycle, so words that
//   expand to 2 or 3 bytes hold the input once the two-entry command queue fills.
//   words that produce nothing (escape still pending) use no queue slot.
// reset and stall
//   synchronous active-low reset empties the queue and returns the escape state
//   to idle. a stalled output holds its word; the front keeps taking input until
//   the queue is full, then raises o_in_stall.
`timescale 1ns / 1ps
`default_nettype none

module percent_decoder (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic                i_cfg_wr_data,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire pctd_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output pctd_pkg::t_out_word      o_out_word
);

    pctd_pkg::t_cmd      cmd;
    pctd_pkg::t_cmd      head;
    pctd_pkg::t_q_status q_status;
    logic                in_accept;
    logic                push;
    logic                pop;

    // input waits only on a full queue, never on the output side directly
    assign o_in_stall = q_status.full;
    assign in_accept  = i_in_valid && !q_status.full;

    // escape classification, emits a command per accepted word that yields bytes
    pctd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_word     (i_in_word),
        .i_accept      (in_accept),
        .o_cmd         (cmd),
        .o_push        (push)
    );

    // decouples the input rate from the byte serialiser
    pctd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (cmd),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // one decoded byte per output word
    pctd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_status    (q_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .o_pop       (pop)
    );

    // empty commands are never queued
    a_head_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.not_empty |-> (head.count != 2'd0))
        else $error("queued command with no bytes");

    // a string end always yields at least one decoded byte
    a_last_yields : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_word.in_last) |-> push)
        else $error("last input word produced no output");

    // a pop only happens on an accepted output word
    a_pop_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (o_out_valid && !i_out_stall))
        else $error("queue popped without an output word");

    // full queue must be presenting data
    a_full_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.full |-> o_out_valid)
        else $error("full queue with output idle");

endmodule

`default_nettype wire
